>>> sv/adsr_pkg.sv
package adsr_pkg;

    // Field widths
    localparam int LEVEL_W  = 15;
    localparam int STEP_W   = 16;
    localparam int CMD_W    = 2;
    localparam int SAMP_W   = 13;
    localparam int SUB_W    = 8;                  // log2 of the quantum
    localparam int TOTAL_W  = SAMP_W;             // sub count plus a saturated chunk fits
    localparam int QCNT_W   = TOTAL_W - SUB_W;    // quanta per advance, up to 16
    localparam int SUM_W    = 18;                 // signed working width of one step
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [SAMP_W-1:0]  MAX_CHUNK = 13'd4096;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'h7fff;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_ON = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP  = 3'd4;

    typedef enum logic [1:0] {
        PH_ATTACK  = 2'd0,
        PH_DECAY   = 2'd1,
        PH_SUSTAIN = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    typedef struct packed {
        logic [LEVEL_W-1:0]       peak_level;
        logic [LEVEL_W-1:0]       hold_level;
        logic [LEVEL_W-1:0]       rise_step;
        logic signed [STEP_W-1:0] fall_step;
        logic signed [STEP_W-1:0] fade_step;
    } t_cfg;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        t_phase             phase;
    } t_env;

    // Clamp a signed working sum into the level range
    function automatic logic [LEVEL_W-1:0] sat_level(input logic signed [SUM_W-1:0] v);
        logic [LEVEL_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({{(SUM_W-LEVEL_W){1'b0}}, LEVEL_MAX})) begin
            r = LEVEL_MAX;
        end else begin
            r = v[LEVEL_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> sv/adsr_cfg_regs.sv
module adsr_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output adsr_pkg::t_cfg                    o_cfg
);

    adsr_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file, writes to unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.peak_level <= adsr_pkg::LEVEL_MAX;
            r_cfg.hold_level <= adsr_pkg::LEVEL_MAX;
            r_cfg.rise_step  <= adsr_pkg::LEVEL_MAX;
            r_cfg.fall_step  <= 16'sh8001;
            r_cfg.fade_step  <= 16'sh8001;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                adsr_pkg::REG_PEAK_LEVEL: begin
                    r_cfg.peak_level <= i_cfg_data[adsr_pkg::LEVEL_W-1:0];
                end
                adsr_pkg::REG_HOLD_LEVEL: begin
                    r_cfg.hold_level <= i_cfg_data[adsr_pkg::LEVEL_W-1:0];
                end
                adsr_pkg::REG_RISE_STEP: begin
                    r_cfg.rise_step <= i_cfg_data[adsr_pkg::LEVEL_W-1:0];
                end
                adsr_pkg::REG_FALL_STEP: begin
                    r_cfg.fall_step <= $signed(i_cfg_data);
                end
                adsr_pkg::REG_FADE_STEP: begin
                    r_cfg.fade_step <= $signed(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> sv/adsr_step_unit.sv
module adsr_step_unit (
    input  adsr_pkg::t_cfg i_cfg,
    input  adsr_pkg::t_env i_env,
    output adsr_pkg::t_env o_env
);

    logic signed [adsr_pkg::SUM_W-1:0] level_ext;
    logic signed [adsr_pkg::SUM_W-1:0] addend;
    logic signed [adsr_pkg::SUM_W-1:0] sum;
    logic signed [adsr_pkg::SUM_W-1:0] peak_ext;
    logic signed [adsr_pkg::SUM_W-1:0] hold_ext;

    localparam int PAD_U = adsr_pkg::SUM_W - adsr_pkg::LEVEL_W;
    localparam int PAD_S = adsr_pkg::SUM_W - adsr_pkg::STEP_W;

    assign level_ext = $signed({{PAD_U{1'b0}}, i_env.level});
    assign peak_ext  = $signed({{PAD_U{1'b0}}, i_cfg.peak_level});
    assign hold_ext  = $signed({{PAD_U{1'b0}}, i_cfg.hold_level});

    // Step size picked by phase, then one shared adder
    always_comb begin
        case (i_env.phase)
            adsr_pkg::PH_ATTACK: addend = $signed({{PAD_U{1'b0}}, i_cfg.rise_step});
            adsr_pkg::PH_DECAY:  addend = $signed({{PAD_S{i_cfg.fall_step[adsr_pkg::STEP_W-1]}},
                                                   i_cfg.fall_step});
            adsr_pkg::PH_RELEASE: addend = $signed({{PAD_S{i_cfg.fade_step[adsr_pkg::STEP_W-1]}},
                                                    i_cfg.fade_step});
            default: addend = '0;
        endcase
    end

    assign sum = level_ext + addend;

    // Snap to the target and move on when reached or crossed
    always_comb begin
        o_env = i_env;
        case (i_env.phase)
            adsr_pkg::PH_ATTACK: begin
                if (sum >= peak_ext) begin
                    o_env.level = i_cfg.peak_level;
                    o_env.phase = adsr_pkg::PH_DECAY;
                end else begin
                    o_env.level = adsr_pkg::sat_level(sum);
                end
            end
            adsr_pkg::PH_DECAY: begin
                if (sum <= hold_ext) begin
                    o_env.level = i_cfg.hold_level;
                    o_env.phase = adsr_pkg::PH_SUSTAIN;
                end else begin
                    o_env.level = adsr_pkg::sat_level(sum);
                end
            end
            adsr_pkg::PH_RELEASE: begin
                o_env.level = adsr_pkg::sat_level(sum);
            end
            default: begin
            end
        endcase
    end

endmodule

>>> sv/adsr_envelope_generator.sv
// The run state applies the N envelope steps due for an accepted word (0..16: one
// per full 256-sample quantum for advance, 1 for note on, 0 otherwise), one step
// per cycle; the push state then moves the result into the output register once
// it is free. A new word is taken only in idle, also while a finished result waits.
// Reset (i_rst_n low, synchronous): level 0, attack phase, counter 0, registers
// back to their defaults, no result pending.
module adsr_envelope_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [12:0] chunk_len, rest zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] cmd
    // Output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [14:0] level, [16:15] phase, rest zero
    // Configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_PUSH
    } t_state;

    adsr_pkg::t_cfg cfg;
    adsr_pkg::t_env step_out;

    t_state                          r_state,   n_state;
    adsr_pkg::t_env                  r_env,     n_env;
    logic [adsr_pkg::SUB_W-1:0]      r_sub,     n_sub;
    logic [adsr_pkg::QCNT_W-1:0]     r_quanta,  n_quanta;
    logic                            r_out_vld, n_out_vld;
    adsr_pkg::t_env                  r_out,     n_out;

    logic [adsr_pkg::SAMP_W-1:0]     samples;
    logic [adsr_pkg::TOTAL_W-1:0]    total;
    logic                            in_fire;

    adsr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    adsr_step_unit u_step (
        .i_cfg (cfg),
        .i_env (r_env),
        .o_env (step_out)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    // Saturate the chunk and split the new count into quanta and remainder
    assign samples = (i_s_axis_tdata[adsr_pkg::SAMP_W-1:0] > adsr_pkg::MAX_CHUNK)
                   ? adsr_pkg::MAX_CHUNK : i_s_axis_tdata[adsr_pkg::SAMP_W-1:0];
    assign total   = {{(adsr_pkg::TOTAL_W-adsr_pkg::SUB_W){1'b0}}, r_sub} + samples;

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {7'd0, r_out.phase, r_out.level};

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_env     = r_env;
        n_sub     = r_sub;
        n_quanta  = r_quanta;
        n_out_vld = r_out_vld;
        n_out     = r_out;

        if (r_out_vld && i_m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state  = S_RUN;
                    n_quanta = '0;
                    case (i_s_axis_tuser)
                        adsr_pkg::CMD_ADVANCE: begin
                            n_sub    = total[adsr_pkg::SUB_W-1:0];
                            n_quanta = total[adsr_pkg::TOTAL_W-1:adsr_pkg::SUB_W];
                        end
                        adsr_pkg::CMD_NOTE_ON: begin
                            n_env.level = '0;
                            n_env.phase = adsr_pkg::PH_ATTACK;
                            n_sub       = '0;
                            n_quanta    = {{(adsr_pkg::QCNT_W-1){1'b0}}, 1'b1};
                        end
                        adsr_pkg::CMD_RELEASE: begin
                            n_env.phase = adsr_pkg::PH_RELEASE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RUN: begin
                // One envelope step per cycle
                if (r_quanta != '0) begin
                    n_env    = step_out;
                    n_quanta = r_quanta - 1'b1;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    n_out_vld = 1'b1;
                    n_out     = r_env;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_env.level <= '0;
            r_env.phase <= adsr_pkg::PH_ATTACK;
            r_sub       <= '0;
            r_quanta    <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_env     <= n_env;
            r_sub     <= n_sub;
            r_quanta  <= n_quanta;
            r_out_vld <= n_out_vld;
        end
        r_out <= n_out;
    end

endmodule

>>> sim/tb_adsr_envelope_generator.sv
module tb_adsr_envelope_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import adsr_pkg::*;

    // cmd value with no defined action, and a register index nothing decodes
    localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd5;

    localparam int QUANTUM_SAMPLES = 256;
    localparam int CHUNK_LIMIT     = 4096;
    localparam int N_SETTINGS      = 9;      // random register settings
    localparam int SETTING_WORDS   = 105;    // minimum input words per setting
    localparam int STALL_SETTING   = 6;      // first setting without idling
    localparam int STALL_CYCLES    = 300;
    localparam int TAIL_CYCLES     = 40;
    localparam int QUIET_LIMIT     = 5000;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_KNOWN,
        ROW_REG
    } t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CMD_W-1:0]     cmd;
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]          value;   // sample count or register data
        t_env                 want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    // Register copy and envelope state of the predictor
    logic [LEVEL_W-1:0]       cfg_peak = LEVEL_MAX;
    logic [LEVEL_W-1:0]       cfg_hold = LEVEL_MAX;
    logic [LEVEL_W-1:0]       cfg_rise = LEVEL_MAX;
    logic signed [STEP_W-1:0] cfg_fall = 16'sh8001;
    logic signed [STEP_W-1:0] cfg_fade = 16'sh8001;
    int                       env_lvl = 0;
    t_phase                   env_ph = PH_ATTACK;
    int                       sub_cnt = 0;

    t_env env_due[$];
    t_row plan[$];

    int n_errors = 0;
    int n_sent = 0;
    int n_results = 0;
    int n_writes = 0;
    int phase_seen[4] = '{0, 0, 0, 0};
    int send_idle_pct = 13;
    int recv_idle_pct = 46;
    int stall_orders = 0;
    int stall_served = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    adsr_envelope_generator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),    // [12:0] chunk_len, rest zero
        .i_s_axis_tuser  (i_s_axis_tuser),    // [1:0] cmd
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),    // [14:0] level, [16:15] phase, rest zero
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Envelope predictor
    // ---------------------------------------------------------------
    function automatic int clip_level(input int v);
        if (v < 0) return 0;
        if (v > int'(LEVEL_MAX)) return int'(LEVEL_MAX);
        return v;
    endfunction

    // One envelope step, as applied per full quantum
    function automatic void env_apply_step();
        int nxt;
        case (env_ph)
            PH_ATTACK: begin
                nxt = env_lvl + int'(cfg_rise);
                if (nxt >= int'(cfg_peak)) begin
                    env_lvl = int'(cfg_peak);
                    env_ph  = PH_DECAY;
                end else begin
                    env_lvl = clip_level(nxt);
                end
            end
            PH_DECAY: begin
                nxt = env_lvl + int'(cfg_fall);
                if (nxt <= int'(cfg_hold)) begin
                    env_lvl = int'(cfg_hold);
                    env_ph  = PH_SUSTAIN;
                end else begin
                    env_lvl = clip_level(nxt);
                end
            end
            PH_RELEASE: begin
                env_lvl = clip_level(env_lvl + int'(cfg_fade));
            end
            default: ;
        endcase
    endfunction

    function automatic t_env env_predict(input logic [CMD_W-1:0] cmd,
                                         input logic [SAMP_W-1:0] samp);
        int   total;
        t_env res;
        case (cmd)
            CMD_ADVANCE: begin
                total = sub_cnt + ((int'(samp) > CHUNK_LIMIT) ? CHUNK_LIMIT : int'(samp));
                sub_cnt = total % QUANTUM_SAMPLES;
                for (int q = 0; q < total / QUANTUM_SAMPLES; q++) env_apply_step();
            end
            CMD_NOTE_ON: begin
                env_lvl = 0;
                sub_cnt = 0;
                env_ph  = PH_ATTACK;
                env_apply_step();
            end
            CMD_RELEASE: begin
                env_ph = PH_RELEASE;
            end
            default: ;
        endcase
        res.level = LEVEL_W'(clip_level(env_lvl));
        res.phase = env_ph;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        if (n_errors <= 40)
            $display("MISMATCH at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_word(input logic [23:0] d);
        t_env got;
        t_env want;
        got.level = d[14:0];
        got.phase = t_phase'(d[16:15]);
        n_results++;
        phase_seen[int'(got.phase)]++;
        if (env_due.size() == 0) begin
            report_mismatch("result word with nothing expected", int'(got.level), -1);
        end else begin
            want = env_due.pop_front();
            if (got.level !== want.level)
                report_mismatch("level", int'(got.level), int'(want.level));
            if (got.phase !== want.phase)
                report_mismatch("phase", int'(got.phase), int'(want.phase));
        end
    endtask

    // Result side: check, then pick ready (random idling, or a long hold-off)
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            check_word(o_m_axis_tdata);
        end
        if (stall_served != stall_orders) begin
            stall_served = stall_orders;
            stall_left   = STALL_CYCLES;
        end
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TIMEOUT: no handshake for %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // Offer one word; valid is left high so back-to-back words need one assignment
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SAMP_W-1:0] samp,
                             input bit known, input t_env want);
        t_env pred;
        i_cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'b000, samp};
        i_s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pred = env_predict(cmd, samp);
        env_due.push_back(known ? want : pred);
        n_sent++;
    endtask

    task automatic await_results();
        i_s_axis_tvalid <= 1'b0;
        while (env_due.size() != 0) @(posedge i_clk);
    endtask

    // Register write, only once every expected result is back
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        await_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_PEAK_LEVEL: cfg_peak = val[LEVEL_W-1:0];
            REG_HOLD_LEVEL: cfg_hold = val[LEVEL_W-1:0];
            REG_RISE_STEP:  cfg_rise = val[LEVEL_W-1:0];
            REG_FALL_STEP:  cfg_fall = val;
            REG_FADE_STEP:  cfg_fade = val;
            default: ;
        endcase
        n_writes++;
    endtask

    function automatic void add_item(input logic [CMD_W-1:0] cmd, input logic [15:0] samp);
        t_row r;
        r.kind  = ROW_ITEM;
        r.cmd   = cmd;
        r.idx   = '0;
        r.value = samp;
        r.want  = '0;
        plan.push_back(r);
    endfunction

    function automatic void add_known(input logic [CMD_W-1:0] cmd, input logic [15:0] samp,
                                      input logic [LEVEL_W-1:0] lvl, input t_phase ph);
        t_row r;
        r.kind       = ROW_KNOWN;
        r.cmd        = cmd;
        r.idx        = '0;
        r.value      = samp;
        r.want.level = lvl;
        r.want.phase = ph;
        plan.push_back(r);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        t_row r;
        r.kind  = ROW_REG;
        r.cmd   = CMD_ADVANCE;
        r.idx   = idx;
        r.value = val;
        r.want  = '0;
        plan.push_back(r);
    endfunction

    // Mostly short chunks, some long, some past the chunk limit
    function automatic logic [SAMP_W-1:0] draw_samples();
        int c;
        c = $urandom_range(0, 99);
        if (c < 70) return SAMP_W'($urandom_range(0, 767));
        if (c < 85) return SAMP_W'($urandom_range(768, 4096));
        if (c < 90) return SAMP_W'($urandom_range(0, 1) ? 4096 : 256);
        return SAMP_W'($urandom_range(4097, 8191));
    endfunction

    function automatic logic [15:0] pick_level();
        int c;
        c = $urandom_range(0, 9);
        if (c == 0) return {1'($urandom), 15'd0};
        if (c == 1) return {1'($urandom), LEVEL_MAX};
        return {1'($urandom), 15'($urandom_range(0, 32767))};
    endfunction

    function automatic logic [15:0] pick_rise();
        int c;
        c = $urandom_range(0, 19);
        if (c == 0) return 16'd0;
        if (c == 1) return 16'd1;
        if (c == 2) return {1'b1, LEVEL_MAX};
        return {1'($urandom), 15'($urandom_range(100, 6000))};
    endfunction

    // Negative steps mostly; now and then zero, positive or the most negative
    function automatic logic [15:0] pick_fall();
        int c;
        c = $urandom_range(0, 19);
        if (c == 0) return 16'hffff;
        if (c == 1) return 16'h8001;
        if (c == 2) return 16'h8000;
        if (c == 3) return 16'($urandom_range(0, 32767));
        return 16'(0 - int'($urandom_range(100, 6000)));
    endfunction

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        t_row r;
        int   sent;
        int   n_adv;
        int   rel_at;

        // Directed table, defaults after reset: full-scale steps
        add_known(CMD_ADVANCE, 16'd0,    15'd0,     PH_ATTACK);
        add_known(CMD_ADVANCE, 16'd255,  15'd0,     PH_ATTACK);
        add_known(CMD_ADVANCE, 16'd1,    LEVEL_MAX, PH_DECAY);
        add_known(CMD_ADVANCE, 16'd8191, LEVEL_MAX, PH_SUSTAIN);
        add_known(CMD_UNUSED,  16'd8191, LEVEL_MAX, PH_SUSTAIN);
        add_known(CMD_RELEASE, 16'd0,    LEVEL_MAX, PH_RELEASE);
        add_known(CMD_ADVANCE, 16'd256,  15'd0,     PH_RELEASE);
        add_known(CMD_ADVANCE, 16'd4096, 15'd0,     PH_RELEASE);
        add_known(CMD_NOTE_ON, 16'd0,    LEVEL_MAX, PH_DECAY);
        add_known(CMD_RELEASE, 16'd8191, LEVEL_MAX, PH_RELEASE);
        add_known(CMD_ADVANCE, 16'd4097, 15'd0,     PH_RELEASE);
        add_known(CMD_UNUSED,  16'd0,    15'd0,     PH_RELEASE);
        // zero rise step holds attack; positive decay step
        add_reg(REG_PEAK_LEVEL, 16'd20000);
        add_reg(REG_HOLD_LEVEL, 16'd5000);
        add_reg(REG_RISE_STEP,  16'd0);
        add_reg(REG_FALL_STEP,  16'd100);
        add_reg(REG_FADE_STEP,  16'hffff);
        add_reg(REG_SPARE,      16'hffff);
        add_item(CMD_NOTE_ON, 16'd4096);
        add_item(CMD_ADVANCE, 16'd4096);
        // peak moved down to the level: the next step snaps to it
        add_reg(REG_PEAK_LEVEL, 16'h8000);
        add_item(CMD_ADVANCE, 16'd256);
        add_item(CMD_ADVANCE, 16'd512);
        // upward decay saturates at full scale until the hold level is raised to it
        add_reg(REG_RISE_STEP,  16'hffff);
        add_reg(REG_PEAK_LEVEL, 16'hffff);
        add_reg(REG_HOLD_LEVEL, 16'd0);
        add_reg(REG_FALL_STEP,  16'd1);
        add_item(CMD_NOTE_ON, 16'd0);
        add_item(CMD_ADVANCE, 16'd4096);
        add_reg(REG_HOLD_LEVEL, 16'h7fff);
        add_reg(REG_FALL_STEP,  16'd0);
        add_item(CMD_ADVANCE, 16'd300);
        // positive release step, then the most negative one
        add_reg(REG_FADE_STEP,  16'h7fff);
        add_item(CMD_RELEASE, 16'd5000);
        add_item(CMD_ADVANCE, 16'd212);
        add_reg(REG_FADE_STEP,  16'h8000);
        add_item(CMD_ADVANCE, 16'd256);
        add_item(CMD_ADVANCE, 16'd1);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            r = plan[k];
            if (r.kind == ROW_REG)
                set_reg(r.idx, r.value);
            else
                send_word(r.cmd, r.value[SAMP_W-1:0], r.kind == ROW_KNOWN, r.want);
        end

        // Random part: one register setting per block of words
        for (int s = 0; s < N_SETTINGS; s++) begin
            if (s < 3) begin
                send_idle_pct = 13;
                recv_idle_pct = 46;
            end else if (s < STALL_SETTING) begin
                send_idle_pct = 46;
                recv_idle_pct = 13;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_reg(REG_PEAK_LEVEL, pick_level());
            set_reg(REG_HOLD_LEVEL, pick_level());
            set_reg(REG_RISE_STEP,  pick_rise());
            set_reg(REG_FALL_STEP,  pick_fall());
            set_reg(REG_FADE_STEP,  pick_fall());
            if (s == STALL_SETTING) stall_orders++;
            sent = 0;
            while (sent < SETTING_WORDS) begin
                if ($urandom_range(0, 99) < 85) begin
                    // note on, a run of advances, a release somewhere in it
                    n_adv  = $urandom_range(1, 8);
                    rel_at = $urandom_range(0, n_adv);
                    send_word(CMD_NOTE_ON, draw_samples(), 1'b0, '0);
                    sent++;
                    for (int a = 0; a < n_adv; a++) begin
                        if (a == rel_at) begin
                            send_word(CMD_RELEASE, draw_samples(), 1'b0, '0);
                            sent++;
                        end
                        send_word(CMD_ADVANCE, draw_samples(), 1'b0, '0);
                        sent++;
                    end
                end else begin
                    case ($urandom_range(0, 3))
                        0: send_word(CMD_UNUSED, draw_samples(), 1'b0, '0);
                        1: send_word(CMD_RELEASE, draw_samples(), 1'b0, '0);
                        2: send_word(CMD_ADVANCE, SAMP_W'($urandom_range(4097, 8191)),
                                     1'b0, '0);
                        default: send_word(CMD_NOTE_ON, draw_samples(), 1'b0, '0);
                    endcase
                    sent++;
                end
            end
        end

        await_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (env_due.size() != 0)
            report_mismatch("results never delivered", 0, env_due.size());

        $display("Run: %0d input words, %0d results checked, %0d register writes, %0d mismatches",
                 n_sent, n_results, n_writes, n_errors);
        $display("Results by phase: attack %0d, decay %0d, sustain %0d, release %0d",
                 phase_seen[0], phase_seen[1], phase_seen[2], phase_seen[3]);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
